// ===== design/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the count-min sketch engine: counter width
// and limit, digest chunk geometry, controller states and the command bundle.
// ----------------------------------------------------------------------------
package cms_pkg;

    // counter geometry
    localparam int CNT_W    = 62;
    localparam int CHUNK_W  = 16;
    localparam int DIGEST_W = 128;
    localparam int MAX_ROWS = 8;
    localparam int FUNC_W   = 1;
    localparam int LEVEL_W  = 6;

    // saturation value of a counter
    localparam logic [CNT_W-1:0] CNT_LIMIT = {CNT_W{1'b1}};

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUO,
        S_REM,
        S_RD,
        S_EVAL,
        S_FIN
    } t_state;

    // controller to datapath step strobes
    typedef struct packed {
        logic load;   // latch accepted item
        logic quo;    // column quotient estimate
        logic rem;    // column remainder
        logic rd;     // bank read
        logic eval;   // pair minima and limit check
        logic fin;    // commit update, load result
        logic clr;    // clearing sweep write
    } t_cmd;

endpackage

// ===== design/cms_in_if.sv =====
// ----------------------------------------------------------------------------
// cms_in_if
// Input item channel: operation, level and 128-bit key digest.
// ----------------------------------------------------------------------------
interface cms_in_if
    import cms_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] level;
    logic [63:0]        digest_lo;
    logic [63:0]        digest_hi;

    modport source (output valid, output func, output level, output digest_lo,
                    output digest_hi, input ready);
    modport sink   (input valid, input func, input level, input digest_lo,
                    input digest_hi, output ready);
endinterface

// ===== design/cms_out_if.sv =====
// ----------------------------------------------------------------------------
// cms_out_if
// Result item channel: estimated count and overflow flag.
// ----------------------------------------------------------------------------
interface cms_out_if
    import cms_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count;
    logic             overflow;

    modport source (output valid, output count, output overflow, input ready);
    modport sink   (input valid, input count, input overflow, output ready);
endinterface

// ===== design/cms_ctrl.sv =====
// ----------------------------------------------------------------------------
// cms_ctrl
// Sequencer of the sketch engine: clearing sweep after reset, then one item
// at a time through quotient, remainder, read, evaluate and commit steps.
// ----------------------------------------------------------------------------
module cms_ctrl
    import cms_pkg::*;
#(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_cmd              o_cmd,
    output logic [ADDR_W-1:0] o_clr_addr
);

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    // state, result valid and sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
        end
    end

    // next state and step strobes
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr  = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_QUO;
                end
            end
            S_QUO: begin
                o_cmd.quo = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_clr_addr  = r_clr_addr;

endmodule

// ===== design/cms_dp.sv =====
// ----------------------------------------------------------------------------
// cms_dp
// Datapath of the sketch engine: per-row column reduction, one counter bank
// per row, limit check, minimum tree and the result register.
// ----------------------------------------------------------------------------
module cms_dp
    import cms_pkg::*;
#(
    parameter int LEVELS       = 64,
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 1024,
    parameter int ADDR_W       = 16
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [ADDR_W-1:0]  i_clr_addr,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [63:0]        i_digest_lo,
    input  logic [63:0]        i_digest_hi,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_overflow
);

    localparam int DEPTH = LEVELS * COLUMN_COUNT;
    localparam int COL_W = $clog2(COLUMN_COUNT);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int REM_W = CHUNK_W + 1;
    localparam int PAIRS = MAX_ROWS / 2;
    // floor(2^32 / COLUMN_COUNT): quotient estimate is exact or one low
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(COLUMN_COUNT));

    function automatic logic [CNT_W-1:0] cnt_min(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    logic [FUNC_W-1:0]  r_func;
    logic [LEVEL_W-1:0] r_level;
    logic [ADDR_W-1:0]  r_base;
    logic [CHUNK_W-1:0] r_chunk [ROW_COUNT];
    logic [CHUNK_W-1:0] r_quo   [ROW_COUNT];
    logic [COL_W-1:0]   r_col   [ROW_COUNT];
    logic [ADDR_W-1:0]  r_addr  [ROW_COUNT];
    logic [CNT_W-1:0]   r_rdata [ROW_COUNT];
    logic [CNT_W-1:0]   r_pair  [PAIRS];
    logic               r_full;
    logic [CNT_W-1:0]   r_count;
    logic               r_overflow;

    logic [DIGEST_W-1:0] w_digest;
    logic [REM_W-1:0]    w_rem  [ROW_COUNT];
    logic [ADDR_W-1:0]   w_addr [ROW_COUNT];
    logic [CNT_W-1:0]    w_pad  [MAX_ROWS];
    logic                w_full;
    logic [CNT_W-1:0]    w_min;
    logic                w_lvl_ok;
    logic                w_upd_we;

    assign w_digest = {i_digest_hi, i_digest_lo};
    assign w_lvl_ok = ({1'b0, r_level} < (LEVEL_W + 1)'(LEVELS));

    // latch item and split digest into per-row chunks
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_level <= i_level;
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_chunk[i] <= w_digest[CHUNK_W*i +: CHUNK_W];
            end
        end
    end

    // quotient estimate by reciprocal, and level base address
    always_ff @(posedge i_clk) begin
        if (i_cmd.quo) begin
            r_base <= ADDR_W'(r_level[LVL_W-1:0]) * ADDR_W'(COLUMN_COUNT);
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_quo[i] <= 16'((48'(r_chunk[i]) * 48'(RECIP)) >> 32);
            end
        end
    end

    // remainder with one correction step
    always_comb begin
        for (int i = 0; i < ROW_COUNT; i++) begin
            w_rem[i] = REM_W'(r_chunk[i])
                     - REM_W'(32'(r_quo[i]) * 32'(COLUMN_COUNT));
            if (w_rem[i] >= REM_W'(COLUMN_COUNT)) begin
                w_rem[i] = w_rem[i] - REM_W'(COLUMN_COUNT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rem) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_col[i] <= w_rem[i][COL_W-1:0];
            end
        end
    end

    // bank addresses; kept for the write-back
    always_comb begin
        for (int i = 0; i < ROW_COUNT; i++) begin
            w_addr[i] = r_base + ADDR_W'(r_col[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_addr[i] <= w_addr[i];
            end
        end
    end

    // commit only a valid-level update with no counter at the limit
    assign w_upd_we = i_cmd.fin && (r_func == FUNC_UPDATE) && w_lvl_ok && !r_full;

    // one counter bank per row
    for (genvar g = 0; g < ROW_COUNT; g++) begin : g_bank
        logic [CNT_W-1:0] r_mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_cmd.clr) begin
                r_mem[i_clr_addr] <= '0;
            end else if (w_upd_we) begin
                r_mem[r_addr[g]] <= r_rdata[g] + 1'b1;
            end
            if (i_cmd.rd) begin
                r_rdata[g] <= r_mem[w_addr[g]];
            end
        end
    end

    // pad missing rows with the limit so they never win the minimum
    always_comb begin
        w_full = 1'b0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            w_pad[i] = CNT_LIMIT;
        end
        for (int i = 0; i < ROW_COUNT; i++) begin
            w_pad[i] = r_rdata[i];
            if (r_rdata[i] == CNT_LIMIT) begin
                w_full = 1'b1;
            end
        end
    end

    // first level of the minimum tree
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_full <= w_full;
            for (int j = 0; j < PAIRS; j++) begin
                r_pair[j] <= cnt_min(w_pad[2*j], w_pad[2*j+1]);
            end
        end
    end

    assign w_min = cnt_min(cnt_min(r_pair[0], r_pair[1]), cnt_min(r_pair[2], r_pair[3]));

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_count    <= ((r_func == FUNC_QUERY) && w_lvl_ok) ? w_min : '0;
            r_overflow <= (r_func == FUNC_UPDATE) && w_lvl_ok && r_full;
        end
    end

    assign o_count    = r_count;
    assign o_overflow = r_overflow;

endmodule

// ===== design/count_min_sketch.sv =====
// ----------------------------------------------------------------------------
// count_min_sketch
// Count-min sketch engine: LEVELS levels of ROW_COUNT rows by COLUMN_COUNT
// 62-bit counters; saturating-refused updates and minimum-over-rows queries.
//
//  channel  dir  payload                              handshake
//  i_in     in   func, level, digest_lo, digest_hi    valid && ready
//  o_out    out  count, overflow                      valid && ready
//
// One item at a time: the accepting cycle, then quotient, remainder, bank
// read, evaluate and commit steps; the commit step loads the result register
// and its valid flag. After reset every bank is swept to zero, one address
// per cycle over all LEVELS * COLUMN_COUNT addresses; no item is accepted
// during the sweep. A new item is accepted while a result waits; the commit
// step holds while the result register is still occupied.
// ----------------------------------------------------------------------------
module count_min_sketch
    import cms_pkg::*;
#(
    parameter int LEVELS       = 64,
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cms_in_if.sink    i_in,
    cms_out_if.source o_out
);

    localparam int DEPTH  = LEVELS * COLUMN_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cmd              w_cmd;
    logic [ADDR_W-1:0] w_clr_addr;

    cms_ctrl #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .o_clr_addr  (w_clr_addr)
    );

    cms_dp #(
        .LEVELS       (LEVELS),
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .ADDR_W       (ADDR_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_clr_addr  (w_clr_addr),
        .i_func      (i_in.func),
        .i_level     (i_in.level),
        .i_digest_lo (i_in.digest_lo),
        .i_digest_hi (i_in.digest_hi),
        .o_count     (o_out.count),
        .o_overflow  (o_out.overflow)
    );

endmodule
